### src/pfdt_pkg.sv
// Shared types, codes and constants for the page frame buffer dirty tracker.
`default_nettype none

package pfdt_pkg;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_BITS  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam int         CFG_IDX_W  = 1;
  localparam int         CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [7:0] WIDTH_RST  = 8'd128;
  localparam logic [6:0] HEIGHT_RST = 7'd64;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OFF = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] column;
    logic [5:0] row;
    logic [7:0] pixel_bits;
    logic [2:0] bit_count;
  } cmd_item_t;

  typedef struct packed {
    logic       status;
    logic [2:0] run_first_page;
    logic [3:0] run_page_count;
    logic       last;
  } rsp_item_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic lo_wr;
    logic hi_wr;
    logic emit_draw;
    logic scan_step;
    logic flush_fin;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic req_flush;
    logic split;
    logic out_ready;
    logic scan_emit;
    logic scan_done;
    logic scan_any;
  } stat_t;

  function automatic logic [7:0] low_mask(input logic [2:0] n);
    logic [7:0] m;
    case (n)
      3'd0: m = 8'h00;
      3'd1: m = 8'h01;
      3'd2: m = 8'h03;
      3'd3: m = 8'h07;
      3'd4: m = 8'h0f;
      3'd5: m = 8'h1f;
      3'd6: m = 8'h3f;
      3'd7: m = 8'h7f;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### src/pfdt_ctrl.sv
// Sequencing state machine: clearing sweep, draw read-modify-write, flush scan.
`default_nettype none

module pfdt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire pfdt_pkg::stat_t stat,
  output pfdt_pkg::ctl_t      ctl
);
  import pfdt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_HI    = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = stat.req_flush ? S_FLUSH : S_LO;
        end
      end
      S_LO: begin
        ctl.lo_wr = 1'b1;
        if (stat.split) begin
          state_next = S_HI;
        end else if (stat.out_ready) begin
          ctl.emit_draw = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_RESP;
        end
      end
      S_HI: begin
        ctl.hi_wr = 1'b1;
        if (stat.out_ready) begin
          ctl.emit_draw = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_ready) begin
          ctl.emit_draw = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.scan_done) begin
          if (stat.scan_any || stat.out_ready) begin
            ctl.flush_fin = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (!stat.scan_emit || stat.out_ready) begin
          ctl.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_hi_after_lo: assert property (@(posedge clk) disable iff (rst)
    (state == S_HI) |-> ($past(state) == S_LO))
    else $error("upper page write without lower page write");

  a_resp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> !$past(stat.out_ready))
    else $error("response wait entered while output was free");

endmodule

`default_nettype wire

### src/pfdt_datapath.sv
// Frame store, dirty mask, configuration, bounds checks, flush scan and output register.
`default_nettype none

module pfdt_datapath #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pfdt_pkg::cmd_item_t                cmd,
  input  wire logic                               cfg_we,
  input  wire logic [pfdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pfdt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire pfdt_pkg::ctl_t                     ctl,
  output pfdt_pkg::stat_t                         stat,
  input  wire logic                               rsp_stall,
  output logic                                    rsp_valid,
  output pfdt_pkg::rsp_item_t                     rsp
);
  import pfdt_pkg::*;

  localparam int         DEPTH    = MAX_PAGES * MAX_COLUMNS;
  localparam int         AW       = $clog2(DEPTH);
  localparam int         PAGE_CAP = (MAX_PAGES < 8) ? MAX_PAGES : 8;
  localparam logic [3:0] PCAP     = 4'(PAGE_CAP);
  localparam logic [8:0] MAXC     = 9'(MAX_COLUMNS);

  function automatic logic [AW-1:0] addr_of(input logic [3:0] page, input logic [6:0] c);
    logic [12:0] a;
    a = 13'(page) * 13'(MAX_COLUMNS) + 13'(c);
    return a[AW-1:0];
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] clr_cnt;

  logic [7:0] width_r;
  logic [6:0] height_r;
  logic [7:0] dirty;

  logic [1:0] act_r;
  logic [6:0] col_r;
  logic [5:0] row_r;
  logic [7:0] bits_r;
  logic [2:0] n_r;

  logic [3:0] p;
  logic       in_run;
  logic [2:0] run_first;
  logic       any;

  logic [3:0]  pages;
  logic [4:0]  pages_raw;
  logic [2:0]  pg;
  logic [2:0]  sh;
  logic        replace;
  logic        is_draw;
  logic [7:0]  val;
  logic [15:0] w;
  logic [15:0] keep16;
  logic [7:0]  mask_lo;
  logic [7:0]  mask_hi;
  logic [7:0]  new0;
  logic [7:0]  new1;
  logic        hi_exists;
  logic        off;
  logic        err_out;
  logic        write_ok;
  logic        lo_we;
  logic        hi_we;
  logic        we;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          out_ready;
  logic          p_lt;
  logic          cur;
  logic          rest_any;
  logic          scan_emit;
  logic          scan_load;
  logic          draw_load;
  logic          empty_load;

  assign pages_raw = 5'(({1'b0, height_r} + 8'd7) >> 3);
  assign pages     = (pages_raw > {1'b0, PCAP}) ? PCAP : pages_raw[3:0];
  assign pg        = row_r[5:3];
  assign sh        = row_r[2:0];
  assign replace   = (act_r == ACT_BYTE);
  assign is_draw   = (act_r == ACT_BYTE) || (act_r == ACT_BITS);
  assign val       = replace ? bits_r : (bits_r & low_mask(n_r));
  assign w         = 16'(val) << sh;
  assign keep16    = 16'h00ff << sh;
  assign mask_lo   = keep16[7:0];
  assign mask_hi   = keep16[15:8];
  assign new0      = replace ? ((rdata & ~mask_lo) | w[7:0]) : (rdata | w[7:0]);
  assign new1      = replace ? ((rdata & ~mask_hi) | w[15:8]) : (rdata | w[15:8]);
  assign hi_exists = (({1'b0, pg} + 4'd1) < pages);

  always_comb begin
    off = ({2'b00, col_r} >= {1'b0, width_r}) || ({2'b00, col_r} >= MAXC) ||
          ({1'b0, row_r} >= height_r) || ({1'b0, pg} >= pages);
    if (replace && (sh != 3'd0) && !hi_exists) begin
      off = 1'b1;
    end
    if (!replace && (w[15:8] != 8'd0) && !hi_exists) begin
      off = 1'b1;
    end
  end

  assign err_out  = is_draw && off;
  assign write_ok = is_draw && !off;

  assign addr0 = addr_of({1'b0, pg}, col_r);
  assign addr1 = addr_of({1'b0, pg} + 4'd1, col_r);
  assign raddr = ctl.load ? addr_of({1'b0, cmd.row[5:3]}, cmd.column) : addr1;

  assign lo_we = ctl.lo_wr && write_ok && (new0 != rdata);
  assign hi_we = ctl.hi_wr && (new1 != rdata);
  assign we    = ctl.clr_wr || lo_we || hi_we;
  assign waddr = ctl.clr_wr ? clr_cnt : (ctl.hi_wr ? addr1 : addr0);
  assign wdata = ctl.clr_wr ? 8'd0 : (ctl.hi_wr ? new1 : new0);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[7:0];
        REG_HEIGHT: height_r <= cfg_data[6:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act_r  <= cmd.action;
      col_r  <= cmd.column;
      row_r  <= cmd.row;
      bits_r <= cmd.pixel_bits;
      n_r    <= cmd.bit_count;
    end
  end

  assign p_lt = (p < pages);
  assign cur  = p_lt && dirty[p[2:0]];

  always_comb begin
    rest_any = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (dirty[i] && (4'(i) >= p) && (4'(i) < pages)) begin
        rest_any = 1'b1;
      end
    end
  end

  assign scan_emit  = in_run && !cur;
  assign scan_load  = ctl.scan_step && scan_emit;
  assign draw_load  = ctl.emit_draw;
  assign empty_load = ctl.flush_fin && !any;

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= '0;
    end else if (ctl.flush_fin) begin
      dirty <= '0;
    end else begin
      if (lo_we) begin
        dirty[pg] <= 1'b1;
      end
      if (hi_we) begin
        dirty[pg + 3'd1] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p      <= '0;
      in_run <= 1'b0;
      any    <= 1'b0;
    end else if (ctl.load) begin
      p      <= '0;
      in_run <= 1'b0;
      any    <= 1'b0;
    end else if (ctl.scan_step) begin
      if (cur) begin
        if (!in_run) begin
          run_first <= p[2:0];
        end
        in_run <= 1'b1;
      end else begin
        in_run <= 1'b0;
        if (in_run) begin
          any <= 1'b1;
        end
      end
      if (p_lt) begin
        p <= p + 4'd1;
      end
    end
  end

  assign out_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (draw_load || scan_load || empty_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_load) begin
      rsp.status         <= err_out ? STATUS_OFF : STATUS_OK;
      rsp.run_first_page <= 3'd0;
      rsp.run_page_count <= 4'd0;
      rsp.last           <= 1'b1;
    end else if (scan_load) begin
      rsp.status         <= STATUS_OK;
      rsp.run_first_page <= run_first;
      rsp.run_page_count <= p - {1'b0, run_first};
      rsp.last           <= !rest_any;
    end else if (empty_load) begin
      rsp.status         <= STATUS_OK;
      rsp.run_first_page <= 3'd0;
      rsp.run_page_count <= 4'd0;
      rsp.last           <= 1'b1;
    end
  end

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_cnt == AW'(DEPTH - 1));
    stat.req_flush = (cmd.action == ACT_FLUSH);
    stat.split     = write_ok && (sh != 3'd0) && hi_exists;
    stat.out_ready = out_ready;
    stat.scan_emit = scan_emit;
    stat.scan_done = !p_lt && !in_run;
    stat.scan_any  = any;
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (draw_load || scan_load || empty_load) |-> out_ready)
    else $error("output register overwritten while holding a transfer");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.flush_fin |=> (dirty == 8'd0))
    else $error("dirty mask not cleared after flush");

  a_hi_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.hi_wr |-> (write_ok && hi_exists))
    else $error("upper page write outside the display");

endmodule

`default_nettype wire

### src/page_framebuffer_dirty_tracker.sv
// Top level of the page frame buffer with dirty page tracking.
//
//   channel  direction  handshake                 payload
//   cmd      in         cmd_valid / cmd_stall     pfdt_pkg::cmd_item_t
//   rsp      out        rsp_valid / rsp_stall     pfdt_pkg::rsp_item_t
//   cfg      in         cfg_we                    cfg_index, cfg_data
//
// A draw loads in the idle state, writes the lower page in S_LO and, when it spans
// two pages, the upper page in S_HI; the frame store, with one read and one write
// port, read-modify-writes one byte a cycle. A flush walks one dirty bit a cycle
// unless a finished run waits for the output register, sending each dirty run.
// After reset the frame store is swept to zero, all MAX_PAGES * MAX_COLUMNS bytes,
// with cmd_stall high; configuration writes are taken during the sweep.
// A stalled rsp holds one result in the output register; the walk pauses until it moves.
`default_nettype none

module page_framebuffer_dirty_tracker #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire pfdt_pkg::cmd_item_t             cmd,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output pfdt_pkg::rsp_item_t                  rsp,
  input  wire logic                            cfg_we,
  input  wire logic [pfdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfdt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfdt_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  pfdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pfdt_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
